// ===== rtl/wst_pkg.sv =====
// ----------------------------------------------------------------------------
// wst_pkg
// types, constants and helpers shared by the wheel speed tachometer
// ----------------------------------------------------------------------------
package wst_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned CountW    = 32;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned DistW     = 48;
  localparam int unsigned ConstW    = 36;
  localparam int unsigned StepW     = 16;
  localparam int unsigned RampStepW = 12;
  localparam int unsigned DataW     = 64;
  localparam int unsigned AddrW     = 6;

  localparam int unsigned DivSteps  = ConstW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [SpeedW-1:0] SpeedCap   = 16'd61440;
  localparam logic [SpeedW-1:0] SpeedMax   = 16'hFFFF;
  localparam logic [DistW-1:0]  TestDistMm = 48'd100000;

  localparam logic [ConstW-1:0] SpeedConstRst = 36'd450000000;
  localparam logic [TimeW-1:0]  StopRst       = 32'd2000000;
  localparam logic [StepW-1:0]  DistStepRst   = 16'd500;
  localparam logic [SpeedW-1:0] LowerRst      = 16'd0;
  localparam logic [SpeedW-1:0] HigherRst     = 16'd61440;
  localparam logic [RampStepW-1:0] RampStepRst = 12'd256;

  typedef enum logic [2:0] {
    REG_TEST_MODE   = 3'd0,
    REG_SPEED_CONST = 3'd1,
    REG_STOP        = 3'd2,
    REG_DIST_STEP   = 3'd3,
    REG_LOWER       = 3'd4,
    REG_HIGHER      = 3'd5,
    REG_RAMP_STEP   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_KEEP   = 2'd0,
    OP_ZERO   = 2'd1,
    OP_DIVIDE = 2'd2,
    OP_RAMP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2
  } back_state_e;

  typedef struct packed {
    logic                 test_mode;
    logic [ConstW-1:0]    speed_const;
    logic [TimeW-1:0]     stop_interval;
    logic [StepW-1:0]     dist_step;
    logic [SpeedW-1:0]    lower;
    logic [SpeedW-1:0]    higher;
    logic [RampStepW-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [TimeW-1:0]  divisor;
    logic [CountW-1:0] edge_count;
    logic              dist_load;
  } cmd_t;

  typedef struct packed {
    logic [SpeedW-1:0] lo;
    logic [SpeedW-1:0] hi;
  } limits_t;

  function automatic limits_t speed_limits(input logic [SpeedW-1:0] lower,
                                           input logic [SpeedW-1:0] higher);
    limits_t l;
    l.hi = (higher > SpeedCap) ? SpeedCap : higher;
    l.lo = lower;
    if (l.lo > l.hi) begin
      l.lo = '0;
      l.hi = SpeedCap;
    end
    return l;
  endfunction

endpackage

// ===== rtl/wst_regs.sv =====
// ----------------------------------------------------------------------------
// wst_regs
// apb register file holding the tachometer configuration
// ----------------------------------------------------------------------------
module wst_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wst_pkg::AddrW-1:0] paddr,
  input  logic [wst_pkg::DataW-1:0] pwdata,
  output logic [wst_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output wst_pkg::cfg_t             cfg_o,
  output logic                      test_load_o
);
  import wst_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel & penable & pwrite;

  always_comb begin
    cfg_d       = cfg_q;
    test_load_o = 1'b0;
    if (wr) begin
      unique case (idx)
        REG_TEST_MODE: begin
          cfg_d.test_mode = pwdata[0];
          test_load_o     = pwdata[0];
        end
        REG_SPEED_CONST: cfg_d.speed_const   = pwdata[ConstW-1:0];
        REG_STOP:        cfg_d.stop_interval = pwdata[TimeW-1:0];
        REG_DIST_STEP:   cfg_d.dist_step     = pwdata[StepW-1:0];
        REG_LOWER:       cfg_d.lower         = pwdata[SpeedW-1:0];
        REG_HIGHER:      cfg_d.higher        = pwdata[SpeedW-1:0];
        REG_RAMP_STEP:   cfg_d.ramp_step     = pwdata[RampStepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TEST_MODE:   prdata = DataW'(cfg_q.test_mode);
      REG_SPEED_CONST: prdata = DataW'(cfg_q.speed_const);
      REG_STOP:        prdata = DataW'(cfg_q.stop_interval);
      REG_DIST_STEP:   prdata = DataW'(cfg_q.dist_step);
      REG_LOWER:       prdata = DataW'(cfg_q.lower);
      REG_HIGHER:      prdata = DataW'(cfg_q.higher);
      REG_RAMP_STEP:   prdata = DataW'(cfg_q.ramp_step);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.test_mode     <= 1'b0;
      cfg_q.speed_const   <= SpeedConstRst;
      cfg_q.stop_interval <= StopRst;
      cfg_q.dist_step     <= DistStepRst;
      cfg_q.lower         <= LowerRst;
      cfg_q.higher        <= HigherRst;
      cfg_q.ramp_step     <= RampStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/wst_front.sv =====
// ----------------------------------------------------------------------------
// wst_front
// samples the sensor, tracks edges and periods, and issues speed commands
// ----------------------------------------------------------------------------
module wst_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wst_pkg::cfg_t              cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wst_pkg::TimeW-1:0]  time_us_i,
  input  logic                       pin_level_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output wst_pkg::cmd_t              q_cmd_o
);
  import wst_pkg::*;

  logic              last_level_q, last_level_d;
  logic              edge_seen_q, edge_seen_d;
  logic [TimeW-1:0]  edge_time_q, edge_time_d;
  logic [TimeW-1:0]  period_q, period_d;
  logic [CountW-1:0] edge_count_q, edge_count_d;

  logic              accept;
  logic              fall;
  logic [TimeW-1:0]  elapsed;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign q_push_o   = accept;
  assign fall       = last_level_q & ~pin_level_i;
  assign elapsed    = time_us_i - edge_time_q;

  always_comb begin
    last_level_d = last_level_q;
    edge_seen_d  = edge_seen_q;
    edge_time_d  = edge_time_q;
    period_d     = period_q;
    edge_count_d = edge_count_q;
    q_cmd_o.op         = OP_KEEP;
    q_cmd_o.divisor    = elapsed;
    q_cmd_o.dist_load  = 1'b0;
    if (cfg_i.test_mode) begin
      q_cmd_o.op = OP_RAMP;
    end else begin
      last_level_d = pin_level_i;
      if (fall) begin
        edge_count_d      = edge_count_q + CountW'(1);
        edge_time_d       = time_us_i;
        edge_seen_d       = 1'b1;
        q_cmd_o.dist_load = 1'b1;
        if (edge_seen_q) begin
          period_d        = elapsed;
          q_cmd_o.op      = OP_DIVIDE;
        end
      end else if (edge_seen_q) begin
        priority if (elapsed > cfg_i.stop_interval) begin
          q_cmd_o.op = OP_ZERO;
        end else if (elapsed > period_q) begin
          q_cmd_o.op = OP_DIVIDE;
        end else begin
          q_cmd_o.op = OP_KEEP;
        end
      end else begin
        q_cmd_o.op = OP_ZERO;
      end
    end
    q_cmd_o.edge_count = edge_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      edge_seen_q  <= 1'b0;
      edge_time_q  <= '0;
      period_q     <= '0;
      edge_count_q <= '0;
    end else if (accept) begin
      last_level_q <= last_level_d;
      edge_seen_q  <= edge_seen_d;
      edge_time_q  <= edge_time_d;
      period_q     <= period_d;
      edge_count_q <= edge_count_d;
    end
  end

endmodule

// ===== rtl/wst_queue.sv =====
// ----------------------------------------------------------------------------
// wst_queue
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
module wst_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wst_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output wst_pkg::cmd_t data_o,
  output logic          empty_o
);
  import wst_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/wst_back.sv =====
// ----------------------------------------------------------------------------
// wst_back
// executes speed commands with a serial divider and drives the result register
// ----------------------------------------------------------------------------
module wst_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wst_pkg::cfg_t               cfg_i,
  input  logic                        test_load_i,
  input  logic                        q_empty_i,
  input  wst_pkg::cmd_t               q_cmd_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wst_pkg::SpeedW-1:0]  speed_o,
  output logic [wst_pkg::CountW-1:0]  transition_count_o,
  output logic [wst_pkg::DistW-1:0]   distance_mm_o
);
  import wst_pkg::*;

  back_state_e        state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [ConstW-1:0]  dq_q, dq_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SpeedW-1:0]  speed_q, speed_d;
  logic               ramp_q, ramp_d;
  logic [DistW-1:0]   dist_q, dist_d;
  logic               out_valid_q, out_valid_d;
  logic [SpeedW-1:0]  out_speed_q, out_speed_d;
  logic [CountW-1:0]  out_count_q, out_count_d;
  logic [DistW-1:0]   out_dist_q, out_dist_d;

  logic               out_free;
  logic               div_last;
  logic               start_div;
  logic [TimeW:0]     trial;
  logic [TimeW+1:0]   diff;
  logic               ge;
  logic [SpeedW-1:0]  quo_sat;
  logic [DistW-1:0]   prod;
  limits_t            lim;
  logic               out_of_range;
  logic               fall;
  logic [SpeedW:0]    sum;

  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign div_last  = (cnt_q == DivCntW'(DivSteps - 1));
  assign start_div = (q_cmd_i.op == OP_DIVIDE) && (q_cmd_i.divisor != '0);
  assign q_pop_o   = (state_q == BK_IDLE) & ~q_empty_i;

  assign trial   = {rem_q, dq_q[ConstW-1]};
  assign diff    = {1'b0, trial} - {2'b00, cmd_q.divisor};
  assign ge      = ~diff[TimeW+1];
  assign quo_sat = (|dq_q[ConstW-1:SpeedW]) ? SpeedMax : dq_q[SpeedW-1:0];
  assign prod    = DistW'(cmd_q.edge_count) * DistW'(cfg_i.dist_step);

  assign lim          = speed_limits(cfg_i.lower, cfg_i.higher);
  assign out_of_range = (speed_q < lim.lo) || (speed_q > lim.hi);
  assign fall         = ramp_q ^ out_of_range;
  assign sum          = {1'b0, speed_q} + (SpeedW + 1)'(cfg_i.ramp_step);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = start_div ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        if (div_last) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    cnt_d       = cnt_q;
    speed_d     = speed_q;
    ramp_d      = ramp_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_speed_d = out_speed_q;
    out_count_d = out_count_q;
    out_dist_d  = out_dist_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          cmd_d = q_cmd_i;
          rem_d = '0;
          dq_d  = cfg_i.speed_const;
          cnt_d = '0;
        end
      end
      BK_DIV: begin
        rem_d = ge ? diff[TimeW-1:0] : trial[TimeW-1:0];
        dq_d  = {dq_q[ConstW-2:0], ge};
        cnt_d = cnt_q + DivCntW'(1);
      end
      BK_FIN: begin
        if (out_free) begin
          unique case (cmd_q.op)
            OP_RAMP: begin
              if (fall) begin
                if (SpeedW'(cfg_i.ramp_step) > speed_q) begin
                  speed_d = '0;
                  ramp_d  = 1'b0;
                end else begin
                  speed_d = speed_q - SpeedW'(cfg_i.ramp_step);
                  ramp_d  = 1'b1;
                end
              end else if (sum[SpeedW]) begin
                speed_d = SpeedMax;
                ramp_d  = 1'b1;
              end else begin
                speed_d = sum[SpeedW-1:0];
                ramp_d  = 1'b0;
              end
            end
            OP_DIVIDE: speed_d = (cmd_q.divisor == '0) ? '0 : quo_sat;
            OP_ZERO:   speed_d = '0;
            OP_KEEP:   speed_d = speed_q;
            default:   speed_d = speed_q;
          endcase
          if (cmd_q.op == OP_RAMP) begin
            dist_d = dist_q + TestDistMm;
          end else if (cmd_q.dist_load) begin
            dist_d = prod;
          end
          out_valid_d = 1'b1;
          out_speed_d = speed_d;
          out_count_d = cmd_q.edge_count;
          out_dist_d  = dist_d;
        end
      end
      default: ;
    endcase
    if (test_load_i) begin
      speed_d = lim.lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      speed_q     <= '0;
      ramp_q      <= 1'b0;
      dist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      ramp_q      <= ramp_d;
      dist_q      <= dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    cnt_q       <= cnt_d;
    out_speed_q <= out_speed_d;
    out_count_q <= out_count_d;
    out_dist_q  <= out_dist_d;
  end

  assign out_valid_o        = out_valid_q;
  assign speed_o            = out_speed_q;
  assign transition_count_o = out_count_q;
  assign distance_mm_o      = out_dist_q;

endmodule

// ===== rtl/wheel_speed_tachometer_core.sv =====
// ----------------------------------------------------------------------------
// wheel_speed_tachometer_core
// Period measuring wheel tachometer. Each sample (timer value and sensor
// level) yields one result with speed in 1/256 km/h, the falling-edge count
// and the distance in mm. The front part tracks edges and periods and takes
// a sample per cycle while its two-entry command queue has room; the back
// part works through one command at a time. A sample that needs a division
// (speed constant over a period or an elapsed time) goes in the back part
// through the bit-serial restoring divider, handling one of the 36 quotient
// bits per cycle; any other sample bypasses it. Results wait in
// an output register while the back part moves on to the next command.
// Configuration sits on an apb port, one 64-bit register every 8 bytes.
// ----------------------------------------------------------------------------
module wheel_speed_tachometer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wst_pkg::AddrW-1:0]   paddr,
  input  logic [wst_pkg::DataW-1:0]   pwdata,
  output logic [wst_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wst_pkg::TimeW-1:0]   time_us_i,
  input  logic                        pin_level_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [wst_pkg::SpeedW-1:0]  speed_o,
  output logic [wst_pkg::CountW-1:0]  transition_count_o,
  output logic [wst_pkg::DistW-1:0]   distance_mm_o
);
  import wst_pkg::*;

  cfg_t cfg;
  logic test_load;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_out;

  wst_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .test_load_o (test_load)
  );

  wst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .time_us_i   (time_us_i),
    .pin_level_i (pin_level_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_in)
  );

  wst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  wst_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .test_load_i        (test_load),
    .q_empty_i          (q_empty),
    .q_cmd_i            (q_out),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .speed_o            (speed_o),
    .transition_count_o (transition_count_o),
    .distance_mm_o      (distance_mm_o)
  );

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wheel speed tachometer core. Samples go in over
// the valid/stall request channel and the registers over the apb port. A
// scoreboard models edge counting, period and decay speed, stop timeout,
// distance and the test-mode speed ramp, and compares every reading that
// comes out, field by field and in order. Directed samples cover the edge
// cases, then random phases change the register settings, with gaps on the
// sample side and stalls on the reading side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wst_pkg::*;

  localparam int unsigned IdleLimit     = 5000;
  localparam int unsigned DrainCycles   = 80;
  localparam int unsigned Phases        = 11;
  localparam int unsigned ItemsPerPhase = 36;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [CountW-1:0] count;
    logic [DistW-1:0]  dist_mm;
  } tach_reading_t;

  class tach_scoreboard;
    logic                 mode_test;
    logic [ConstW-1:0]    speed_k;
    logic [TimeW-1:0]     stop_us;
    logic [StepW-1:0]     dist_step;
    logic [SpeedW-1:0]    lower;
    logic [SpeedW-1:0]    higher;
    logic [RampStepW-1:0] ramp_step;

    logic              last_level;
    logic              edge_seen;
    logic [TimeW-1:0]  last_edge_t;
    logic [TimeW-1:0]  last_period;
    logic [SpeedW-1:0] speed;
    logic [CountW-1:0] edge_cnt;
    logic [DistW-1:0]  total_mm;
    logic              ramp_down;

    tach_reading_t expected_readings[$];
    int unsigned   errors;

    function new();
      mode_test   = 1'b0;
      speed_k     = SpeedConstRst;
      stop_us     = StopRst;
      dist_step   = DistStepRst;
      lower       = LowerRst;
      higher      = HigherRst;
      ramp_step   = RampStepRst;
      last_level  = 1'b0;
      edge_seen   = 1'b0;
      last_edge_t = '0;
      last_period = '0;
      speed       = '0;
      edge_cnt    = '0;
      total_mm    = '0;
      ramp_down   = 1'b0;
      errors      = 0;
    endfunction

    function void ramp_bounds(output logic [SpeedW-1:0] lo, output logic [SpeedW-1:0] hi);
      hi = (higher > SpeedCap) ? SpeedCap : higher;
      lo = lower;
      if (lo > hi) begin
        lo = '0;
        hi = SpeedCap;
      end
    endfunction

    function logic [SpeedW-1:0] rate_of(logic [TimeW-1:0] span);
      logic [ConstW-1:0] q;
      if (span == '0) return '0;
      q = speed_k / ConstW'(span);
      if (q > ConstW'(SpeedMax)) return SpeedMax;
      return q[SpeedW-1:0];
    endfunction

    function void write_reg(reg_idx_e idx, logic [DataW-1:0] value);
      logic [SpeedW-1:0] lo, hi;
      case (idx)
        REG_TEST_MODE: begin
          mode_test = value[0];
          if (mode_test) begin
            ramp_bounds(lo, hi);
            speed = lo;
          end
        end
        REG_SPEED_CONST: speed_k = value[ConstW-1:0];
        REG_STOP:        stop_us = value[TimeW-1:0];
        REG_DIST_STEP:   dist_step = value[StepW-1:0];
        REG_LOWER:       lower = value[SpeedW-1:0];
        REG_HIGHER:      higher = value[SpeedW-1:0];
        REG_RAMP_STEP:   ramp_step = value[RampStepW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [TimeW-1:0] stamp, logic level);
      logic [SpeedW-1:0] lo, hi;
      logic [SpeedW:0]   sum;
      logic [TimeW-1:0]  span;
      logic [63:0]       prod;
      if (mode_test) begin
        ramp_bounds(lo, hi);
        if (speed < lo || speed > hi) ramp_down = !ramp_down;
        if (ramp_down) begin
          if (SpeedW'(ramp_step) > speed) begin
            speed = '0;
            ramp_down = 1'b0;
          end else begin
            speed = speed - SpeedW'(ramp_step);
          end
        end else begin
          sum = {1'b0, speed} + (SpeedW+1)'(ramp_step);
          if (sum[SpeedW]) begin
            speed = SpeedMax;
            ramp_down = 1'b1;
          end else begin
            speed = sum[SpeedW-1:0];
          end
        end
        total_mm = total_mm + TestDistMm;
      end else begin
        if (last_level && !level) begin
          edge_cnt = edge_cnt + CountW'(1);
          if (edge_seen) begin
            last_period = stamp - last_edge_t;
            speed = rate_of(last_period);
          end
          prod = 64'(edge_cnt) * 64'(dist_step);
          total_mm = prod[DistW-1:0];
          last_edge_t = stamp;
          edge_seen = 1'b1;
        end
        if (edge_seen) begin
          span = stamp - last_edge_t;
          if (span > last_period) speed = rate_of(span);
          if (span > stop_us) speed = '0;
        end else begin
          speed = '0;
        end
        last_level = level;
      end
      expected_readings.push_back('{speed: speed, count: edge_cnt, dist_mm: total_mm});
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [SpeedW-1:0] s, logic [CountW-1:0] c, logic [DistW-1:0] d);
      tach_reading_t want;
      if (expected_readings.size() == 0) begin
        report("unexpected reading, speed", 64'(s), 64'(0));
      end else begin
        want = expected_readings.pop_front();
        if (s !== want.speed) report("speed", 64'(s), 64'(want.speed));
        if (c !== want.count) report("transition_count", 64'(c), 64'(want.count));
        if (d !== want.dist_mm) report("distance_mm", 64'(d), 64'(want.dist_mm));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [TimeW-1:0]  time_us_i;
  logic              pin_level_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [SpeedW-1:0] speed_o;
  logic [CountW-1:0] transition_count_o;
  logic [DistW-1:0]  distance_mm_o;

  tach_scoreboard sb;
  int unsigned    gap_pct;
  int unsigned    stall_pct;
  int unsigned    quiet_cycles;
  logic           ramp_active;
  logic [TimeW-1:0] stamp_us;
  logic             pin_now;

  wheel_speed_tachometer_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .time_us_i          (time_us_i),
    .pin_level_i        (pin_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .speed_o            (speed_o),
    .transition_count_o (transition_count_o),
    .distance_mm_o      (distance_mm_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(speed_o, transition_count_o, distance_mm_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample request, with random gaps before it
  task automatic send_sample(logic [TimeW-1:0] stamp, logic level);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    time_us_i   <= stamp;
    pin_level_i <= level;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(stamp, level);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
  endtask

  task automatic wait_drained();
    while (sb.expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned ph);
    logic [DataW-1:0] mode, k, stop, dstep, lo, hi, st;
    mode  = 0;
    k     = 64'(SpeedConstRst);
    stop  = 64'(StopRst);
    dstep = 64'(DistStepRst);
    lo    = 64'(LowerRst);
    hi    = 64'(HigherRst);
    st    = 64'(RampStepRst);
    case (ph)
      1: begin
        k = 64'h0F_FFFF_FFFF;
        stop = 64'hFFFF_FFFF;
        dstep = 64'hFFFF;
      end
      2: begin
        mode = 1;
        lo = 1000;
        hi = 5000;
        st = 4095;
      end
      3: begin
        k = 0;
        stop = 0;
        dstep = 0;
      end
      4: begin
        mode = 1;
        lo = 64'hFFFF;
        hi = 64'hFFFF;
        st = 0;
      end
      5: begin
        k = 64'($urandom_range(900000000));
        stop = 64'($urandom_range(10000000));
        dstep = 64'($urandom_range(65535));
      end
      6: begin
        mode = 1;
        lo = 64'($urandom_range(40000));
        hi = 64'($urandom_range(65535, 20000));
        st = 64'($urandom_range(4095));
      end
      7: begin
        stop = 100000;
        dstep = 1;
      end
      8: begin
        mode = 1;
        lo = 61440;
        hi = 61440;
        st = 4095;
      end
      9: begin
        mode = 1;
        lo = 0;
        hi = 3000;
        st = 2500;
      end
      10: begin
        k = {$urandom_range(15), $urandom};
        stop = 64'($urandom);
        dstep = 64'($urandom_range(65535));
      end
      default: ;
    endcase
    apb_write(REG_SPEED_CONST, k);
    apb_write(REG_STOP, stop);
    apb_write(REG_DIST_STEP, dstep);
    apb_write(REG_LOWER, lo);
    apb_write(REG_HIGHER, hi);
    apb_write(REG_RAMP_STEP, st);
    apb_write(REG_TEST_MODE, mode);
    psel    <= 1'b0;
    penable <= 1'b0;
    ramp_active = mode[0];
  endtask

  // mostly plausible wheel pulses, with repeats, long pauses and timer jumps
  task automatic run_phase(int unsigned count);
    logic [TimeW-1:0] delta;
    for (int unsigned i = 0; i < count; i++) begin
      if (ramp_active) begin
        send_sample($urandom, 1'($urandom_range(1)));
      end else begin
        case ($urandom_range(19))
          0:       delta = $urandom;
          1, 2, 3: delta = $urandom_range(3);
          4, 5, 6: delta = $urandom_range(4000000);
          default: delta = $urandom_range(30000, 1000);
        endcase
        stamp_us = stamp_us + delta;
        if ($urandom_range(9) < 7) pin_now = !pin_now;
        send_sample(stamp_us, pin_now);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  logic [TimeW-1:0] dir_stamp [20] = '{
    32'd0, 32'd0, 32'd100, 32'd200, 32'd200, 32'd200, 32'd300, 32'd5000,
    32'd20000, 32'd20000, 32'd2100000, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0000_1000,
    32'h0000_2000, 32'h0000_4710, 32'h0000_8000, 32'h0000_9000, 32'h8000_0000,
    32'h8000_0000
  };
  logic dir_pin [20] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0
  };

  initial begin
    sb           = new();
    gap_pct      = 0;
    stall_pct    = 0;
    quiet_cycles = 0;
    ramp_active  = 1'b0;
    stamp_us     = $urandom;
    pin_now      = 1'b0;
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    time_us_i   <= '0;
    pin_level_i <= 1'b0;
    out_stall_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 20; i++) send_sample(dir_stamp[i], dir_pin[i]);
    in_valid_i <= 1'b0;

    for (int unsigned ph = 0; ph < Phases; ph++) begin
      wait_drained();
      set_config(ph);
      case (ph % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 70;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 70;
        end
        default: begin
          gap_pct = 21;
          stall_pct = 21;
        end
      endcase
      run_phase(ItemsPerPhase);
    end

    wait_drained();
    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.expected_readings.size() != 0) begin
      sb.report("readings missing", 64'(0), 64'(sb.expected_readings.size()));
    end
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wst_pkg.sv
rtl/wst_regs.sv
rtl/wst_front.sv
rtl/wst_queue.sv
rtl/wst_back.sv
rtl/wheel_speed_tachometer_core.sv
test/tb.sv
